>>> rtl/blake3_hash_256_defines.svh
// ----------------------------------------------------------------------------
// blake3_hash_256_defines
// Assertion macros used by the blake3_hash_256 top module.
// ----------------------------------------------------------------------------
`ifndef BLAKE3_HASH_256_DEFINES_SVH
`define BLAKE3_HASH_256_DEFINES_SVH

// same-cycle implication, reset masked
`define B3H_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("blake3 check failed");

// next-cycle implication, reset masked
`define B3H_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("blake3 check failed");

`endif

>>> rtl/b3h_pkg.sv
// ----------------------------------------------------------------------------
// b3h_pkg
// Types, constants and helpers of the BLAKE3 hash core.
// ----------------------------------------------------------------------------
package b3h_pkg;

  typedef logic [31:0] word_t;

  localparam word_t IV [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam int PERM [16] = '{2, 6, 3, 10, 7, 0, 4, 13, 1, 11, 12, 5, 9, 14, 15, 8};

  localparam logic [3:0] FLAG_START  = 4'd1;
  localparam logic [3:0] FLAG_END    = 4'd2;
  localparam logic [3:0] FLAG_PARENT = 4'd4;
  localparam logic [3:0] FLAG_ROOT   = 4'd8;

  localparam logic [6:0] BLOCK_BYTES = 7'd64;

  typedef struct packed {
    logic [7:0][31:0]  hin;
    logic [15:0][31:0] msg;
    logic [63:0]       ctr;
    logic [6:0]        blen;
    logic [3:0]        flags;
  } comp_req_t;

  function automatic word_t ror(input word_t x, input int n);
    return word_t'((x >> n) | (x << (32 - n)));
  endfunction

endpackage

>>> rtl/b3h_mix.sv
// ----------------------------------------------------------------------------
// b3h_mix
// Half of the BLAKE3 G function: one message word, three adds, two rotates.
// ----------------------------------------------------------------------------
module b3h_mix (
  input  logic          second_half,
  input  b3h_pkg::word_t a_in,
  input  b3h_pkg::word_t b_in,
  input  b3h_pkg::word_t c_in,
  input  b3h_pkg::word_t d_in,
  input  b3h_pkg::word_t m_in,
  output b3h_pkg::word_t a_out,
  output b3h_pkg::word_t b_out,
  output b3h_pkg::word_t c_out,
  output b3h_pkg::word_t d_out
);
  import b3h_pkg::*;

  word_t dx;
  word_t bx;

  always_comb begin
    a_out = a_in + b_in + m_in;
    dx    = d_in ^ a_out;
    d_out = second_half ? ror(dx, 8) : ror(dx, 16);
    c_out = c_in + d_out;
    bx    = b_in ^ c_out;
    b_out = second_half ? ror(bx, 7) : ror(bx, 12);
  end

endmodule

>>> rtl/b3h_comp.sv
// ----------------------------------------------------------------------------
// b3h_comp
// Iterative compression: one half G step per cycle, 112 steps per block.
// ----------------------------------------------------------------------------
module b3h_comp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  b3h_pkg::comp_req_t req,
  output logic              busy,
  output logic              done,
  output logic [7:0][31:0]  cv_out
);
  import b3h_pkg::*;

  word_t      v_r   [16];
  word_t      v_nxt [16];
  word_t      vm    [16];
  word_t      msg_r   [16];
  word_t      msg_nxt [16];
  logic [3:0] step_r, step_nxt;
  logic [2:0] round_r, round_nxt;
  logic       busy_r, busy_nxt;
  logic       done_r, done_nxt;
  word_t      a_o, b_o, c_o, d_o;

  b3h_mix u_mix (
    .second_half (step_r[0]),
    .a_in        (v_r[0]),
    .b_in        (v_r[4]),
    .c_in        (v_r[8]),
    .d_in        (v_r[12]),
    .m_in        (msg_r[0]),
    .a_out       (a_o),
    .b_out       (b_o),
    .c_out       (c_o),
    .d_out       (d_o)
  );

  always_comb begin
    v_nxt     = v_r;
    msg_nxt   = msg_r;
    step_nxt  = step_r;
    round_nxt = round_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    vm        = v_r;
    vm[0]     = a_o;
    vm[4]     = b_o;
    vm[8]     = c_o;
    vm[12]    = d_o;
    if (start) begin
      for (int i = 0; i < 8; i++) begin
        v_nxt[i] = req.hin[i];
      end
      for (int i = 0; i < 4; i++) begin
        v_nxt[8 + i] = IV[i];
      end
      v_nxt[12] = req.ctr[31:0];
      v_nxt[13] = req.ctr[63:32];
      v_nxt[14] = {25'd0, req.blen};
      v_nxt[15] = {28'd0, req.flags};
      for (int i = 0; i < 16; i++) begin
        msg_nxt[i] = req.msg[i];
      end
      step_nxt  = '0;
      round_nxt = '0;
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      v_nxt = vm;
      // after a full G, rotate rows; diagonalize or undo at phase ends
      if (step_r[0]) begin
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++) begin
            if (step_r[3:1] == 3'd3) begin
              v_nxt[r*4 + c] = vm[r*4 + ((c + 1 + r) % 4)];
            end else if (step_r[3:1] == 3'd7) begin
              v_nxt[r*4 + c] = vm[r*4 + ((c + 5 - r) % 4)];
            end else begin
              v_nxt[r*4 + c] = vm[r*4 + ((c + 1) % 4)];
            end
          end
        end
      end
      if (step_r == 4'd15) begin
        for (int i = 0; i < 16; i++) begin
          msg_nxt[i] = msg_r[(PERM[i] + 1) % 16];
        end
      end else begin
        for (int i = 0; i < 16; i++) begin
          msg_nxt[i] = msg_r[(i + 1) % 16];
        end
      end
      step_nxt = step_r + 4'd1;
      if (step_r == 4'd15) begin
        round_nxt = round_r + 3'd1;
        if (round_r == 3'd6) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      step_r  <= '0;
      round_r <= '0;
    end else begin
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      step_r  <= step_nxt;
      round_r <= round_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r   <= v_nxt;
    msg_r <= msg_nxt;
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      cv_out[i] = v_r[i] ^ v_r[i + 8];
    end
  end

  assign busy = busy_r;
  assign done = done_r;

endmodule

>>> rtl/blake3_hash_256.sv
// One item at a time; its valid bytes are absorbed one by one, and a full block is compressed
// when the next byte arrives. A chunk close compresses its last block and a parent per merge.
// Last item: the final chunk and a parent per stacked value are compressed, the last as root;
// then one digest transfer per cycle unless out_stall is high. A single half-G unit sets the pace.
// Reset: synchronous active-low rst_n clears control, chaining value and buffer.
// The chaining value stack memory is not cleared; only entries below the count are used.
// ----------------------------------------------------------------------------
// blake3_hash_256
// Unkeyed BLAKE3 with a 32-byte digest over a byte stream of 64-bit words.
// ----------------------------------------------------------------------------
`include "blake3_hash_256_defines.svh"

module blake3_hash_256 #(
  parameter int STACK_DEPTH = 54
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_data_word,
  input  logic [3:0]  in_byte_count,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_digest_word,
  output logic [1:0]  out_word_index,
  output logic        out_last_word
);
  import b3h_pkg::*;

  localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int SIDX_W    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int MEM_DEPTH = STACK_DEPTH * 8;
  localparam int ADDR_W    = SIDX_W + 3;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ABS   = 4'd1;
  localparam logic [3:0] S_WBLK  = 4'd2;
  localparam logic [3:0] S_WCHK  = 4'd3;
  localparam logic [3:0] S_MERGE = 4'd4;
  localparam logic [3:0] S_LOAD  = 4'd5;
  localparam logic [3:0] S_WPAR  = 4'd6;
  localparam logic [3:0] S_PUSH  = 4'd7;
  localparam logic [3:0] S_CRST  = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;
  localparam logic [3:0] S_FLOOP = 4'd10;
  localparam logic [3:0] S_WFIN  = 4'd11;
  localparam logic [3:0] S_WROOT = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0]        state_r, state_nxt;
  logic [63:0]       data_r, data_nxt;
  logic [3:0]        cnt_r, cnt_nxt;
  logic              last_r, last_nxt;
  logic [3:0]        k_r, k_nxt;
  logic [15:0][31:0] buf_r, buf_nxt;
  logic [6:0]        fill_r, fill_nxt;
  logic [3:0]        bd_r, bd_nxt;
  logic [7:0][31:0]  cv_r, cv_nxt;
  logic [63:0]       chunk_r, chunk_nxt;
  logic [63:0]       total_r, total_nxt;
  logic [CNT_W-1:0]  sc_r, sc_nxt;
  logic [7:0][31:0]  node_r, node_nxt;
  comp_req_t         req_r, req_nxt;
  logic              start_r, start_nxt;
  logic              fin_r, fin_nxt;
  logic [3:0]        j_r, j_nxt;
  logic [7:0][31:0]  digest_r, digest_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_idx_r, out_idx_nxt;

  logic              comp_busy;
  logic              comp_done;
  logic [7:0][31:0]  comp_cv;

  word_t             stack_mem [MEM_DEPTH];
  word_t             rd_data_r;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  word_t             wr_data;
  logic              mem_we;
  logic [7:0][31:0]  iv_cv;
  logic [SIDX_W-1:0] sc_idx;

  b3h_comp u_comp (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start_r),
    .req    (req_r),
    .busy   (comp_busy),
    .done   (comp_done),
    .cv_out (comp_cv)
  );

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      iv_cv[i] = IV[i];
    end
  end

  assign sc_idx  = sc_r[SIDX_W-1:0];
  assign rd_addr = {sc_idx, j_r[2:0]};
  assign wr_addr = {sc_idx, j_r[2:0]};
  assign wr_data = node_r[j_r[2:0]];

  always_comb begin
    state_nxt     = state_r;
    data_nxt      = data_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    k_nxt         = k_r;
    buf_nxt       = buf_r;
    fill_nxt      = fill_r;
    bd_nxt        = bd_r;
    cv_nxt        = cv_r;
    chunk_nxt     = chunk_r;
    total_nxt     = total_r;
    sc_nxt        = sc_r;
    node_nxt      = node_r;
    req_nxt       = req_r;
    start_nxt     = 1'b0;
    fin_nxt       = fin_r;
    j_nxt         = j_r;
    digest_nxt    = digest_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    mem_we        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          data_nxt  = in_data_word;
          cnt_nxt   = (in_byte_count > 4'd8) ? 4'd8 : in_byte_count;
          last_nxt  = in_last;
          k_nxt     = '0;
          state_nxt = S_ABS;
        end
      end
      S_ABS: begin
        if (k_r == cnt_r) begin
          state_nxt = last_r ? S_FIN : S_IDLE;
        end else if (fill_r == BLOCK_BYTES) begin
          req_nxt.hin  = cv_r;
          req_nxt.msg  = buf_r;
          req_nxt.ctr  = chunk_r;
          req_nxt.blen = fill_r;
          start_nxt    = 1'b1;
          if (bd_r == 4'd15) begin
            req_nxt.flags = FLAG_END;
            state_nxt     = S_WCHK;
          end else begin
            req_nxt.flags = (bd_r == 4'd0) ? FLAG_START : 4'd0;
            state_nxt     = S_WBLK;
          end
        end else begin
          buf_nxt[fill_r[5:2]][{fill_r[1:0], 3'b000} +: 8] = data_r[7:0];
          data_nxt = {8'd0, data_r[63:8]};
          fill_nxt = fill_r + 7'd1;
          k_nxt    = k_r + 4'd1;
        end
      end
      S_WBLK: begin
        if (comp_done) begin
          cv_nxt    = comp_cv;
          bd_nxt    = bd_r + 4'd1;
          buf_nxt   = '0;
          fill_nxt  = '0;
          state_nxt = S_ABS;
        end
      end
      S_WCHK: begin
        if (comp_done) begin
          node_nxt  = comp_cv;
          chunk_nxt = chunk_r + 64'd1;
          total_nxt = chunk_r + 64'd1;
          state_nxt = S_MERGE;
        end
      end
      S_MERGE: begin
        if (!total_r[0] && sc_r != '0) begin
          sc_nxt            = sc_r - CNT_W'(1);
          req_nxt.msg[15:8] = node_r;
          j_nxt             = '0;
          fin_nxt           = 1'b0;
          state_nxt         = S_LOAD;
        end else if (sc_r < CNT_W'(STACK_DEPTH)) begin
          j_nxt     = '0;
          state_nxt = S_PUSH;
        end else begin
          state_nxt = S_CRST;
        end
      end
      S_LOAD: begin
        if (j_r != 4'd0) begin
          for (int i = 0; i < 7; i++) begin
            req_nxt.msg[i] = req_r.msg[i + 1];
          end
          req_nxt.msg[7] = rd_data_r;
        end
        j_nxt = j_r + 4'd1;
        if (j_r == 4'd8) begin
          req_nxt.hin   = iv_cv;
          req_nxt.ctr   = '0;
          req_nxt.blen  = BLOCK_BYTES;
          req_nxt.flags = FLAG_PARENT;
          if (fin_r) begin
            state_nxt = S_FLOOP;
          end else begin
            start_nxt = 1'b1;
            state_nxt = S_WPAR;
          end
        end
      end
      S_WPAR: begin
        if (comp_done) begin
          node_nxt  = comp_cv;
          total_nxt = {1'b0, total_r[63:1]};
          state_nxt = S_MERGE;
        end
      end
      S_PUSH: begin
        mem_we = 1'b1;
        j_nxt  = j_r + 4'd1;
        if (j_r[2:0] == 3'd7) begin
          sc_nxt    = sc_r + CNT_W'(1);
          state_nxt = S_CRST;
        end
      end
      S_CRST: begin
        cv_nxt    = iv_cv;
        buf_nxt   = '0;
        fill_nxt  = '0;
        bd_nxt    = '0;
        state_nxt = S_ABS;
      end
      S_FIN: begin
        req_nxt.hin   = cv_r;
        req_nxt.msg   = buf_r;
        req_nxt.ctr   = chunk_r;
        req_nxt.blen  = fill_r;
        req_nxt.flags = FLAG_END | ((bd_r == 4'd0) ? FLAG_START : 4'd0);
        state_nxt     = S_FLOOP;
      end
      S_FLOOP: begin
        start_nxt = 1'b1;
        if (sc_r != '0) begin
          state_nxt = S_WFIN;
        end else begin
          req_nxt.ctr   = '0;
          req_nxt.flags = req_r.flags | FLAG_ROOT;
          state_nxt     = S_WROOT;
        end
      end
      S_WFIN: begin
        if (comp_done) begin
          sc_nxt            = sc_r - CNT_W'(1);
          req_nxt.msg[15:8] = comp_cv;
          j_nxt             = '0;
          fin_nxt           = 1'b1;
          state_nxt         = S_LOAD;
        end
      end
      S_WROOT: begin
        if (comp_done) begin
          digest_nxt    = comp_cv;
          out_valid_nxt = 1'b1;
          out_idx_nxt   = '0;
          state_nxt     = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          if (out_idx_r == 2'd3) begin
            out_valid_nxt = 1'b0;
            cv_nxt        = iv_cv;
            buf_nxt       = '0;
            fill_nxt      = '0;
            bd_nxt        = '0;
            chunk_nxt     = '0;
            sc_nxt        = '0;
            state_nxt     = S_IDLE;
          end else begin
            out_idx_nxt = out_idx_r + 2'd1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
      out_idx_r   <= '0;
      sc_r        <= '0;
      fill_r      <= '0;
      bd_r        <= '0;
      chunk_r     <= '0;
      cv_r        <= iv_cv;
      buf_r       <= '0;
      fin_r       <= 1'b0;
      j_r         <= '0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
      out_idx_r   <= out_idx_nxt;
      sc_r        <= sc_nxt;
      fill_r      <= fill_nxt;
      bd_r        <= bd_nxt;
      chunk_r     <= chunk_nxt;
      cv_r        <= cv_nxt;
      buf_r       <= buf_nxt;
      fin_r       <= fin_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r   <= data_nxt;
    cnt_r    <= cnt_nxt;
    last_r   <= last_nxt;
    total_r  <= total_nxt;
    node_r   <= node_nxt;
    req_r    <= req_nxt;
    digest_r <= digest_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= stack_mem[rd_addr];
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_word_index  = out_idx_r;
  assign out_last_word   = (out_idx_r == 2'd3);
  assign out_digest_word = {digest_r[{out_idx_r, 1'b1}], digest_r[{out_idx_r, 1'b0}]};

  `B3H_ASSERT(a_stack_bound, 1'b1, sc_r <= CNT_W'(STACK_DEPTH))
  `B3H_ASSERT(a_fill_bound, 1'b1, fill_r <= BLOCK_BYTES)
  `B3H_ASSERT(a_start_unit_free, start_r, !comp_busy)
  `B3H_ASSERT_NEXT(a_clear_after_digest, out_valid_r && !out_stall && out_idx_r == 2'd3, state_r == S_IDLE && sc_r == '0 && chunk_r == '0 && fill_r == '0)

endmodule

>>> tb/sv/tb_blake3_hash_256.sv
// ----------------------------------------------------------------------------
// tb_blake3_hash_256
// Self-checking bench for the unkeyed BLAKE3-256 stream hasher. Messages of
// many lengths (empty, single block, block and chunk borders, multi-chunk
// trees) go in as 64-bit word transfers under several idle/stall patterns;
// a scoreboard hashes the same bytes and checks all four digest words.
// ----------------------------------------------------------------------------
module tb_blake3_hash_256;
  timeunit 1ns;
  timeprecision 1ps;

  import b3h_pkg::*;

  localparam int STACK_DEPTH = 54;

  class hash_scoreboard;
    typedef struct {
      logic [63:0] word;
      logic [1:0]  index;
      logic        last;
    } digest_word_t;

    word_t        cv [8];
    logic [7:0]   blk [64];
    int unsigned  fill;
    int unsigned  blocks;
    logic [63:0]  chunks;
    word_t        stk [STACK_DEPTH][8];
    int unsigned  depth;
    word_t        v [16];
    digest_word_t pending [$];
    int unsigned  mismatches;
    int unsigned  words_checked;
    int unsigned  messages;

    function new();
      reset_state();
    endfunction

    function void chunk_restart();
      for (int i = 0; i < 8; i++) cv[i] = IV[i];
      for (int i = 0; i < 64; i++) blk[i] = 8'h00;
      fill = 0;
      blocks = 0;
    endfunction

    function void reset_state();
      chunk_restart();
      chunks = 0;
      depth = 0;
    endfunction

    function word_t rotr(word_t x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void mix(int a, int b, int c, int d, word_t x, word_t y);
      v[a] = v[a] + v[b] + x;
      v[d] = rotr(v[d] ^ v[a], 16);
      v[c] = v[c] + v[d];
      v[b] = rotr(v[b] ^ v[c], 12);
      v[a] = v[a] + v[b] + y;
      v[d] = rotr(v[d] ^ v[a], 8);
      v[c] = v[c] + v[d];
      v[b] = rotr(v[b] ^ v[c], 7);
    endfunction

    function void compress(input word_t hin [8], input word_t m [16], input logic [63:0] ctr,
                           input word_t len, input logic [3:0] fl, output word_t res [16]);
      word_t msg [16];
      word_t tmp [16];
      for (int i = 0; i < 8; i++) begin
        v[i] = hin[i];
        v[i + 8] = IV[i];
      end
      v[12] = ctr[31:0];
      v[13] = ctr[63:32];
      v[14] = len;
      v[15] = word_t'(fl);
      msg = m;
      for (int r = 0; r < 7; r++) begin
        mix(0, 4, 8, 12, msg[0], msg[1]);
        mix(1, 5, 9, 13, msg[2], msg[3]);
        mix(2, 6, 10, 14, msg[4], msg[5]);
        mix(3, 7, 11, 15, msg[6], msg[7]);
        mix(0, 5, 10, 15, msg[8], msg[9]);
        mix(1, 6, 11, 12, msg[10], msg[11]);
        mix(2, 7, 8, 13, msg[12], msg[13]);
        mix(3, 4, 9, 14, msg[14], msg[15]);
        for (int i = 0; i < 16; i++) tmp[i] = msg[PERM[i]];
        msg = tmp;
      end
      for (int i = 0; i < 8; i++) begin
        res[i] = v[i] ^ v[i + 8];
        res[i + 8] = v[i + 8] ^ hin[i];
      end
    endfunction

    function void pack_block(output word_t w [16]);
      for (int i = 0; i < 16; i++)
        w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
    endfunction

    function logic [3:0] chunk_flags();
      return (blocks == 0 ? FLAG_START : 4'd0) | FLAG_END;
    endfunction

    function void close_chunk();
      word_t       w [16];
      word_t       res [16];
      word_t       node [8];
      word_t       pair [16];
      logic [63:0] total;
      pack_block(w);
      compress(cv, w, chunks, word_t'(fill), chunk_flags(), res);
      for (int i = 0; i < 8; i++) node[i] = res[i];
      chunks++;
      total = chunks;
      while (total[0] == 1'b0 && depth > 0) begin
        depth--;
        for (int i = 0; i < 8; i++) begin
          pair[i] = stk[depth][i];
          pair[i + 8] = node[i];
        end
        compress(IV, pair, 64'd0, word_t'(BLOCK_BYTES), FLAG_PARENT, res);
        for (int i = 0; i < 8; i++) node[i] = res[i];
        total = total >> 1;
      end
      if (depth < STACK_DEPTH) begin
        for (int i = 0; i < 8; i++) stk[depth][i] = node[i];
        depth++;
      end
      chunk_restart();
    endfunction

    function void absorb(logic [7:0] b);
      word_t w [16];
      word_t res [16];
      if (fill >= 64) begin
        if (blocks >= 15) begin
          close_chunk();
        end else begin
          pack_block(w);
          compress(cv, w, chunks, word_t'(BLOCK_BYTES), blocks == 0 ? FLAG_START : 4'd0, res);
          for (int i = 0; i < 8; i++) cv[i] = res[i];
          blocks++;
          for (int i = 0; i < 64; i++) blk[i] = 8'h00;
          fill = 0;
        end
      end
      blk[fill & 63] = b;
      fill++;
    endfunction

    function void finalize(output word_t dig [8]);
      word_t       h [8];
      word_t       w [16];
      word_t       res [16];
      word_t       len;
      logic [3:0]  fl;
      logic [63:0] ctr;
      h = cv;
      pack_block(w);
      len = word_t'(fill);
      fl = chunk_flags();
      ctr = chunks;
      while (depth > 0) begin
        compress(h, w, ctr, len, fl, res);
        depth--;
        for (int i = 0; i < 8; i++) begin
          w[i] = stk[depth][i];
          w[i + 8] = res[i];
        end
        h = IV;
        len = word_t'(BLOCK_BYTES);
        fl = FLAG_PARENT;
        ctr = 0;
      end
      compress(h, w, 64'd0, len, fl | FLAG_ROOT, res);
      for (int i = 0; i < 8; i++) dig[i] = res[i];
    endfunction

    function void note_input(logic [63:0] data, logic [3:0] cnt, logic last);
      int unsigned  n;
      word_t        dig [8];
      digest_word_t e;
      n = (cnt > 8) ? 8 : cnt;
      for (int i = 0; i < n; i++) absorb(data[8*i +: 8]);
      if (last) begin
        finalize(dig);
        for (int i = 0; i < 4; i++) begin
          e.word = {dig[2*i+1], dig[2*i]};
          e.index = 2'(i);
          e.last = (i == 3);
          pending.push_back(e);
        end
        reset_state();
        messages++;
      end
    endfunction

    function void check_digest(logic [63:0] word, logic [1:0] index, logic last);
      digest_word_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected digest word %h index %0d last %0b", word, index, last);
        return;
      end
      e = pending.pop_front();
      words_checked++;
      if (word !== e.word || index !== e.index || last !== e.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: digest exp %h/%0d/%0b got %h/%0d/%0b",
                   e.word, e.index, e.last, word, index, last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [63:0] in_data_word;
  logic [3:0]  in_byte_count;
  logic        in_last;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_digest_word;
  logic [1:0]  out_word_index;
  logic        out_last_word;

  hash_scoreboard sb = new();
  int unsigned    send_idle_pct;
  int unsigned    recv_stall_pct;
  int unsigned    items_sent;
  int unsigned    total_bytes;

  blake3_hash_256 i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_word   (in_data_word),
    .in_byte_count  (in_byte_count),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_digest_word(out_digest_word),
    .out_word_index (out_word_index),
    .out_last_word  (out_last_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_digest(out_digest_word, out_word_index, out_last_word);
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic send_item(logic [63:0] data, logic [3:0] cnt, logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      in_data_word = {$urandom, $urandom};
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data_word = data;
    in_byte_count = cnt;
    in_last = last;
    do @(posedge clk); while (in_stall);
    sb.note_input(data, cnt, last);
    items_sent++;
    total_bytes += (cnt > 8) ? 8 : cnt;
  endtask

  // pattern: 0 random, 1 all ones, 2 all zeros
  task automatic send_message(int unsigned nbytes, int pattern);
    int unsigned full;
    int unsigned rem;
    logic [63:0] d;
    full = nbytes / 8;
    rem = nbytes % 8;
    for (int i = 0; i < full; i++) begin
      d = (pattern == 1) ? '1 : (pattern == 2) ? '0 : {$urandom, $urandom};
      if (pattern == 0 && $urandom_range(19) == 0)
        send_item({$urandom, $urandom}, 4'd0, 1'b0);
      if (i == full - 1 && rem == 0 && $urandom_range(1) == 1) begin
        send_item(d, $urandom_range(3) == 0 ? 4'($urandom_range(15, 9)) : 4'd8, 1'b1);
        return;
      end
      send_item(d, (pattern == 0 && $urandom_range(9) == 0) ? 4'($urandom_range(15, 9)) : 4'd8,
                1'b0);
    end
    d = (pattern == 1) ? '1 : (pattern == 2) ? '0 : {$urandom, $urandom};
    send_item(d, 4'(rem), 1'b1);
  endtask

  task automatic send_random_message();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 90) send_message($urandom_range(130), 0);
    else send_message($urandom_range(400, 131), 0);
  endtask

  initial begin
    int unsigned phase_start;
    in_valid = 1'b0;
    in_data_word = '0;
    in_byte_count = '0;
    in_last = 1'b0;
    out_stall = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    items_sent = 0;
    total_bytes = 0;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_item({$urandom, $urandom}, 4'd0, 1'b1);
    send_item({$urandom, $urandom}, 4'd15, 1'b1);
    send_item({$urandom, $urandom}, 4'd0, 1'b0);
    send_item({$urandom, $urandom}, 4'd0, 1'b0);
    send_item({$urandom, $urandom}, 4'd3, 1'b1);
    send_message(64, 2);
    send_message(65, 1);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      phase_start = items_sent;
      if (ph == 0) send_message(2049, 0);
      while (items_sent - phase_start < 45) send_random_message();
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("Hashed %0d messages (%0d bytes in %0d transfers), checked %0d digest words.",
             sb.messages, total_bytes, items_sent, sb.words_checked);
    $display("Mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
